### design/vgn_pkg.sv
// Shared types, constants and symbol mapping functions for the alphanumeric cipher unit.
`default_nettype none

package vgn_pkg;

    // Largest number of key symbols held in the key register.
    localparam int KEY_MAX_DEF = 10;

    // Register file geometry: 64-bit data, registers at byte addresses 8*i.
    localparam int DATA_W    = 64;
    localparam int PADDR_W   = 5;
    localparam int KEY_W     = 60;
    localparam int KEY_LEN_W = 4;
    localparam int CODE_W    = 6;
    localparam int CHAR_W    = 7;
    localparam int BYTE_W    = 8;

    // Register indexes as decoded from paddr[4:3].
    localparam logic [1:0] REG_KEY_CODES   = 2'd0;
    localparam logic [1:0] REG_KEY_LENGTH  = 2'd1;
    localparam logic [1:0] REG_CIPHER_MODE = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 4'd1;

    // Cipher modes.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Alphabet: A-Z are codes 0-25, 0-9 are codes 26-35.
    localparam logic [CODE_W-1:0] SYMBOLS = 6'd36;
    localparam logic [CODE_W-1:0] LETTERS = 6'd26;

    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIGIT_9 = 8'h39;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [KEY_W-1:0]     key_codes;
        logic [KEY_LEN_W-1:0] key_length;
        logic                 cipher_mode;
    } vgn_cfg_t;

    // A classified input byte.
    typedef struct packed {
        logic              kept;
        logic [CODE_W-1:0] code;
    } vgn_sym_t;

    // Maps a raw byte to a symbol code; bytes that are not letters or digits are dropped.
    function automatic vgn_sym_t char_to_code(input logic [BYTE_W-1:0] b);
        vgn_sym_t sym;
        sym.kept = 1'b1;
        sym.code = '0;
        if (b inside {[CH_LOWER_A:CH_LOWER_Z]})
        begin
            sym.code = CODE_W'(b - CH_LOWER_A);
        end
        else if (b inside {[CH_UPPER_A:CH_UPPER_Z]})
        begin
            sym.code = CODE_W'(b - CH_UPPER_A);
        end
        else if (b inside {[CH_DIGIT_0:CH_DIGIT_9]})
        begin
            sym.code = CODE_W'(b - CH_DIGIT_0) + LETTERS;
        end
        else
        begin
            sym.kept = 1'b0;
        end
        return sym;
    endfunction

    // Adds two codes whose sum is below 72 and reduces the sum modulo 36.
    function automatic logic [CODE_W-1:0] add_mod36(input logic [CODE_W-1:0] a,
                                                    input logic [CODE_W-1:0] b);
        logic [CODE_W:0] sum;
        sum = (CODE_W+1)'(a) + (CODE_W+1)'(b);
        if (sum >= (CODE_W+1)'(SYMBOLS))
        begin
            return CODE_W'(sum - (CODE_W+1)'(SYMBOLS));
        end
        return CODE_W'(sum);
    endfunction

    // Maps a code 0..35 back to an uppercase letter or digit.
    function automatic logic [CHAR_W-1:0] code_to_char(input logic [CODE_W-1:0] c);
        if (c < LETTERS)
        begin
            return CHAR_W'(CH_UPPER_A) + CHAR_W'(c);
        end
        return CHAR_W'(CH_DIGIT_0) + CHAR_W'(c) - CHAR_W'(LETTERS);
    endfunction

endpackage

`default_nettype wire

### design/vgn_cfg_regs.sv
// APB-style register file holding the key, the key length and the cipher mode.
`default_nettype none

module vgn_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vgn_pkg::PADDR_W-1:0] paddr,
    input  wire logic [vgn_pkg::DATA_W-1:0]  pwdata,
    output logic      [vgn_pkg::DATA_W-1:0]  prdata,
    output vgn_pkg::vgn_cfg_t                cfg
);
    import vgn_pkg::*;

    logic [KEY_W-1:0]     key_codes_reg;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic                 cipher_mode_reg;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_codes_reg   <= '0;
            key_length_reg  <= KEY_LEN_RESET;
            cipher_mode_reg <= MODE_ENCRYPT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KEY_CODES:   key_codes_reg   <= pwdata[KEY_W-1:0];
                REG_KEY_LENGTH:  key_length_reg  <= pwdata[KEY_LEN_W-1:0];
                REG_CIPHER_MODE: cipher_mode_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEY_CODES:   prdata = DATA_W'(key_codes_reg);
            REG_KEY_LENGTH:  prdata = DATA_W'(key_length_reg);
            REG_CIPHER_MODE: prdata = DATA_W'(cipher_mode_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.key_codes   = key_codes_reg;
    assign cfg.key_length  = key_length_reg;
    assign cfg.cipher_mode = cipher_mode_reg;

endmodule

`default_nettype wire

### design/vgn_core.sv
// Cipher datapath: input register, key position counter, mod-36 combine and result register.
`default_nettype none

module vgn_core #(
    parameter int KEY_MAX = vgn_pkg::KEY_MAX_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [vgn_pkg::BYTE_W-1:0] raw_char,
    input  wire logic                       message_start,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [vgn_pkg::CHAR_W-1:0] cipher_char,
    input  vgn_pkg::vgn_cfg_t               cfg
);
    import vgn_pkg::*;

    localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam logic [KEY_LEN_W-1:0] LEN_MAX = KEY_LEN_W'(KEY_MAX);

    logic                 s1_valid_reg;
    logic [BYTE_W-1:0]    s1_char_reg;
    logic                 s1_start_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    cipher_char_reg;

    vgn_sym_t             text_sym;
    logic [KEY_LEN_W-1:0] len_use;
    logic [POS_W-1:0]     pos_cur;
    logic [POS_W-1:0]     pos_eff;
    logic [KEY_LEN_W-1:0] pos_inc;
    logic [POS_W-1:0]     pos_wrap;
    logic [CODE_W-1:0]    key_sym [KEY_MAX];
    logic [CODE_W-1:0]    key_raw;
    logic [CODE_W-1:0]    key_mod;
    logic [CODE_W-1:0]    key_term;
    logic [CODE_W-1:0]    res_code;
    logic                 advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg  <= raw_char;
            s1_start_reg <= message_start;
        end
    end

    assign text_sym = char_to_code(s1_char_reg);

    // Length in use: zero counts as one, anything above the key size saturates.
    always_comb
    begin
        if (cfg.key_length == '0)
        begin
            len_use = KEY_LEN_W'(1);
        end
        else if (cfg.key_length > LEN_MAX)
        begin
            len_use = LEN_MAX;
        end
        else
        begin
            len_use = cfg.key_length;
        end
    end

    always_comb
    begin
        for (int k = 0; k < KEY_MAX; k++)
        begin
            key_sym[k] = cfg.key_codes[CODE_W*k +: CODE_W];
        end
    end

    // A position left beyond a newly shortened key restarts at symbol zero.
    assign pos_cur  = s1_start_reg ? '0 : pos_reg;
    assign pos_eff  = (KEY_LEN_W'(pos_cur) >= len_use) ? '0 : pos_cur;
    assign key_raw  = key_sym[pos_eff];
    assign key_mod  = (key_raw >= SYMBOLS) ? (key_raw - SYMBOLS) : key_raw;
    assign key_term = (cfg.cipher_mode == MODE_DECRYPT) ? (SYMBOLS - key_mod) : key_mod;
    assign res_code = add_mod36(text_sym.code, key_term);

    assign pos_inc  = KEY_LEN_W'(pos_eff) + KEY_LEN_W'(1);
    assign pos_wrap = (pos_inc >= len_use) ? '0 : POS_W'(pos_inc);

    // Dropped bytes leave the stage without needing the result register.
    assign advance  = s1_valid_reg && (!text_sym.kept || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        pos_next = pos_reg;
        if (advance)
        begin
            pos_next = text_sym.kept ? pos_wrap : pos_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (advance && text_sym.kept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && text_sym.kept)
        begin
            cipher_char_reg <= code_to_char(res_code);
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_char = cipher_char_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        KEY_LEN_W'(pos_reg) < LEN_MAX)
        else $error("key position beyond key size");

    a_result_alnum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (cipher_char_reg >= CHAR_W'(CH_UPPER_A) && cipher_char_reg <= CHAR_W'(CH_UPPER_Z))
            || (cipher_char_reg >= CHAR_W'(CH_DIGIT_0)
                && cipher_char_reg <= CHAR_W'(CH_DIGIT_9)))
        else $error("result is not an uppercase letter or digit");

    a_start_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_start_reg && !text_sym.kept |=> pos_reg == '0)
        else $error("start of message on a dropped byte did not clear key position");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_char_reg))
        else $error("stalled input stage lost its transaction");

endmodule

`default_nettype wire

### design/vigenere_alnum_stream_cipher_unit.sv
// Top level of the alphanumeric Vigenere stream cipher unit.
// The unit takes one raw byte per cycle while no kept byte waits on the output. A kept byte's
// result passes through the input register, then the result register.
// A result that waits on the output holds back only kept bytes; dropped bytes still pass.
// Bytes that are not letters or digits give no result and do not advance the key position.
// Configuration registers sit at byte addresses 0 (key codes, six bits per symbol),
// 8 (key length) and 16 (mode: 0 encrypt, 1 decrypt). The user must write them only while
// idle; the block itself does not enforce this.
`default_nettype none

module vigenere_alnum_stream_cipher_unit #(
    parameter int KEY_MAX = vgn_pkg::KEY_MAX_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [vgn_pkg::BYTE_W-1:0]  raw_char,
    input  wire logic                        message_start,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [vgn_pkg::CHAR_W-1:0]  cipher_char,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vgn_pkg::PADDR_W-1:0] paddr,
    input  wire logic [vgn_pkg::DATA_W-1:0]  pwdata,
    output logic      [vgn_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    import vgn_pkg::*;

    vgn_cfg_t cfg;

    assign pready = 1'b1;

    vgn_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    vgn_core #(
        .KEY_MAX (KEY_MAX)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .raw_char      (raw_char),
        .message_start (message_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cipher_char   (cipher_char),
        .cfg           (cfg)
    );

endmodule

`default_nettype wire
